/* rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, command codes and sizing constants.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int DELAY_WIDTH = 16;
  localparam int DELAY_RESET = 5;

  localparam logic [2:0] REQ_NONE  = 3'd0;
  localparam logic [2:0] REQ_INIT  = 3'd1;
  localparam logic [2:0] REQ_START = 3'd2;
  localparam logic [2:0] REQ_STOP  = 3'd3;
  localparam logic [2:0] REQ_WRITE = 3'd4;
  localparam logic [2:0] REQ_READ  = 3'd5;

  localparam int STEP_W     = 5;
  localparam int BYTE_STEPS = 24;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] tx;
    logic       send_ack;
    logic       sda_in;
  } i2cm_item_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic busy;
    logic done;
    logic [7:0] rx;
    logic ack;
  } i2cm_res_t;

  function automatic logic [STEP_W-1:0] step_total(input logic [2:0] c);
    logic [STEP_W-1:0] t;
    t = STEP_W'(BYTE_STEPS + 4);
    case (c)
      REQ_INIT:  t = STEP_W'(2);
      REQ_START: t = STEP_W'(3);
      REQ_STOP:  t = STEP_W'(2);
      default:   t = STEP_W'(BYTE_STEPS + 4);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* rtl/i2cm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts tick items, folds unknown requests into none, queues them.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic       in_send_ack,
  input  wire logic       in_sda_in,
  output logic            q_valid,
  output i2cm_item_t      q_item,
  input  wire logic       q_pop
);

  i2cm_item_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]       cnt_r, cnt_nxt;
  logic                  push;
  logic                  pop;
  i2cm_item_t            item;

  always_comb begin
    item.tx       = in_tx_byte;
    item.send_ack = in_send_ack;
    item.sda_in   = in_sda_in;
    unique case (in_req_type) inside
      REQ_INIT, REQ_START, REQ_STOP, REQ_WRITE, REQ_READ: item.req = in_req_type;
      default: item.req = REQ_NONE;
    endcase
  end

  assign in_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/i2cm_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master back end
// Runs the SCL/SDA step sequencer one tick per queued item, registers result.
// ----------------------------------------------------------------------------
module i2cm_back
  import i2cm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [DELAY_WIDTH-1:0] delay_ticks,
  input  wire logic                   q_valid,
  input  wire i2cm_item_t             q_item,
  output logic                        q_pop,
  output logic                        res_valid,
  output i2cm_res_t                   res,
  input  wire logic                   res_ready
);

  logic                   busy_r, busy_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [1:0]             sub_r, sub_nxt;
  logic [DELAY_WIDTH-1:0] dcnt_r, dcnt_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   ack_r, ack_nxt;
  logic                   ackm_r, ackm_nxt;
  logic                   done;
  logic                   do_step;
  logic [2:0]             c;
  logic [STEP_W-1:0]      s;
  logic [1:0]             sb;
  logic [7:0]             sh;
  logic [DELAY_WIDTH-1:0] unit_m1;
  logic                   out_valid_r;
  i2cm_res_t              res_r;

  // zero delay behaves as one tick per unit
  assign unit_m1 = (delay_ticks == '0) ? '0 : delay_ticks - 1'b1;

  assign q_pop = q_valid && (!out_valid_r || res_ready);

  always_comb begin
    busy_nxt  = busy_r;
    cmd_nxt   = cmd_r;
    dcnt_nxt  = dcnt_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rx_nxt    = rx_r;
    ack_nxt   = ack_r;
    ackm_nxt  = ackm_r;
    done      = 1'b0;
    do_step   = 1'b0;
    c         = cmd_r;
    s         = step_r;
    sb        = sub_r;
    sh        = shift_r;

    if (!busy_r) begin
      if (q_item.req != REQ_NONE) begin
        busy_nxt = 1'b1;
        c        = q_item.req;
        cmd_nxt  = q_item.req;
        s        = '0;
        sb       = '0;
        if (q_item.req == REQ_WRITE) begin
          sh = q_item.tx;
        end
        if (q_item.req == REQ_READ) begin
          sh       = '0;
          ackm_nxt = q_item.send_ack;
        end
        do_step = 1'b1;
      end
    end else if (dcnt_r != '0) begin
      dcnt_nxt = dcnt_r - 1'b1;
    end else begin
      s  = step_r + 1'b1;
      sb = (sub_r == 2'd2) ? 2'd0 : sub_r + 1'b1;
      if (s >= step_total(cmd_r)) begin
        busy_nxt = 1'b0;
        s        = '0;
        sb       = '0;
        done     = 1'b1;
      end else begin
        do_step = 1'b1;
      end
    end

    step_nxt  = s;
    sub_nxt   = sb;
    shift_nxt = sh;

    if (do_step) begin
      dcnt_nxt = unit_m1;
      unique case (c)
        REQ_INIT: begin
          if (s == '0) sda_nxt = 1'b1;
          else scl_nxt = 1'b1;
        end
        REQ_START: begin
          if (s == '0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else if (s == STEP_W'(1)) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        REQ_STOP: begin
          if (s == '0) begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        REQ_WRITE: begin
          if (s < STEP_W'(BYTE_STEPS)) begin
            if (sb == 2'd0) begin
              sda_nxt = sh[7];
            end else if (sb == 2'd1) begin
              scl_nxt   = 1'b1;
              shift_nxt = {sh[6:0], 1'b0};
            end else begin
              scl_nxt = 1'b0;
            end
          end else if (s == STEP_W'(BYTE_STEPS)) begin
            sda_nxt = 1'b1;
          end else if (s == STEP_W'(BYTE_STEPS + 1)) begin
            scl_nxt = 1'b1;
          end else if (s == STEP_W'(BYTE_STEPS + 2)) begin
            ack_nxt = q_item.sda_in;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        default: begin
          if (s < STEP_W'(BYTE_STEPS)) begin
            if (sb == 2'd0) begin
              scl_nxt = 1'b1;
              if (s == '0) sda_nxt = 1'b1;
            end else if (sb == 2'd1) begin
              shift_nxt = {sh[6:0], q_item.sda_in};
            end else begin
              scl_nxt = 1'b0;
            end
          end else if (s == STEP_W'(BYTE_STEPS)) begin
            rx_nxt  = sh;
            sda_nxt = !ackm_r;
          end else if (s == STEP_W'(BYTE_STEPS + 1)) begin
            scl_nxt = 1'b1;
          end else if (s == STEP_W'(BYTE_STEPS + 2)) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  // advance the engine only on ticks that are taken from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cmd_r   <= REQ_NONE;
      step_r  <= '0;
      sub_r   <= '0;
      dcnt_r  <= '0;
      shift_r <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      rx_r    <= '0;
      ack_r   <= 1'b1;
      ackm_r  <= 1'b0;
    end else if (q_pop) begin
      busy_r  <= busy_nxt;
      cmd_r   <= cmd_nxt;
      step_r  <= step_nxt;
      sub_r   <= sub_nxt;
      dcnt_r  <= dcnt_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      rx_r    <= rx_nxt;
      ack_r   <= ack_nxt;
      ackm_r  <= ackm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r.scl  <= scl_nxt;
      res_r.sda  <= sda_nxt;
      res_r.busy <= busy_nxt;
      res_r.done <= done;
      res_r.rx   <= rx_nxt;
      res_r.ack  <= ack_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

/* rtl/i2c_master_bit_engine_top.sv */
// A transferred tick item is queued, then its result is registered for output.
// Throughput: one item and one sequencer tick per cycle unless out_ready stalls.
// The two-entry queue and the output register let either side stall alone.
// Reset: synchronous active-low rst_n idles the engine, releases SCL and SDA,
// empties the queue and loads delay_ticks with 5.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit engine top
// Config register, front queue and back-end sequencer.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top
  import i2cm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [DELAY_WIDTH-1:0] cfg_delay_ticks,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             in_req_type,
  input  wire logic [7:0]             in_tx_byte,
  input  wire logic                   in_send_ack,
  input  wire logic                   in_sda_in,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_scl_level,
  output logic                        out_sda_level,
  output logic                        out_busy_res,
  output logic                        out_done_res,
  output logic [7:0]                  out_rx_byte,
  output logic                        out_ack_received
);

  logic [DELAY_WIDTH-1:0] delay_r;
  logic                   q_valid;
  logic                   q_pop;
  i2cm_item_t             q_item;
  i2cm_res_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_WIDTH'(DELAY_RESET);
    end else if (cfg_valid && cfg_ready) begin
      delay_r <= cfg_delay_ticks;
    end
  end

  i2cm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_tx_byte  (in_tx_byte),
    .in_send_ack (in_send_ack),
    .in_sda_in   (in_sda_in),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  i2cm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .delay_ticks (delay_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .res_valid   (out_valid),
    .res         (res),
    .res_ready   (out_ready)
  );

  assign out_scl_level    = res.scl;
  assign out_sda_level    = res.sda;
  assign out_busy_res     = res.busy;
  assign out_done_res     = res.done;
  assign out_rx_byte      = res.rx;
  assign out_ack_received = res.ack;

  // a finishing tick never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done and busy reported together");

  // input back-pressure only arises from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  // a done tick follows a busy tick
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 (out_valid && out_ready && out_done_res)
      |-> $past(out_busy_res))
    else $error("done without a running sequence");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives one bus tick per transfer, keeps its own copy of the engine's step
// sequencing and compares every status transfer field by field, across
// several delay units, random stalls and a final maximum-length unit.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cm_pkg::*;

  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  localparam int LIMIT      = 1_000_000;
  localparam int SETTLE     = 4;
  localparam int LONG_TICKS = 40;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DELAY_WIDTH-1:0] cfg_delay_ticks = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [2:0]             in_req_type = REQ_NONE;
  logic [7:0]             in_tx_byte = '0;
  logic                   in_send_ack = 1'b0;
  logic                   in_sda_in = 1'b1;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_scl_level;
  logic                   out_sda_level;
  logic                   out_busy_res;
  logic                   out_done_res;
  logic [7:0]             out_rx_byte;
  logic                   out_ack_received;

  // engine copy, at its reset values
  logic [DELAY_WIDTH-1:0] unit_ticks = DELAY_WIDTH'(DELAY_RESET);
  logic                   eng_busy = 1'b0;
  logic [2:0]             eng_cmd = REQ_NONE;
  int unsigned            eng_step = 0;
  int unsigned            eng_wait = 0;
  logic [7:0]             eng_shift = '0;
  logic                   eng_scl = 1'b1;
  logic                   eng_sda = 1'b1;
  logic [7:0]             eng_rx = '0;
  logic                   eng_ack = 1'b1;
  logic                   eng_ack_mode = 1'b0;

  i2cm_res_t status_q[$];
  int        n_errors = 0;
  int        cycle_count = 0;
  bit        calm = 1'b0;
  bit        quiet = 1'b0;

  i2c_master_bit_engine_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_delay_ticks  (cfg_delay_ticks),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_tx_byte       (in_tx_byte),
    .in_send_ack      (in_send_ack),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_level    (out_scl_level),
    .out_sda_level    (out_sda_level),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_rx_byte      (out_rx_byte),
    .out_ack_received (out_ack_received)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Line changes of the current step, then load one delay unit.
  function automatic void apply_step(input logic sda_smp);
    int unsigned sub;
    sub = eng_step % 3;
    case (eng_cmd)
      REQ_INIT: begin
        if (eng_step == 0) eng_sda = 1'b1;
        else eng_scl = 1'b1;
      end
      REQ_START: begin
        if (eng_step == 0) begin
          eng_sda = 1'b1;
          eng_scl = 1'b1;
        end else if (eng_step == 1) eng_sda = 1'b0;
        else eng_scl = 1'b0;
      end
      REQ_STOP: begin
        if (eng_step == 0) begin
          eng_sda = 1'b0;
          eng_scl = 1'b1;
        end else eng_sda = 1'b1;
      end
      REQ_WRITE: begin
        if (eng_step < BYTE_STEPS) begin
          if (sub == 0) eng_sda = eng_shift[7];
          else if (sub == 1) begin
            eng_scl = 1'b1;
            eng_shift = eng_shift << 1;
          end else eng_scl = 1'b0;
        end else if (eng_step == BYTE_STEPS) eng_sda = 1'b1;
        else if (eng_step == BYTE_STEPS + 1) eng_scl = 1'b1;
        else if (eng_step == BYTE_STEPS + 2) eng_ack = sda_smp;
        else eng_scl = 1'b0;
      end
      default: begin
        if (eng_step < BYTE_STEPS) begin
          if (sub == 0) begin
            eng_scl = 1'b1;
            if (eng_step == 0) eng_sda = 1'b1;
          end else if (sub == 1) eng_shift = {eng_shift[6:0], sda_smp};
          else eng_scl = 1'b0;
        end else if (eng_step == BYTE_STEPS) begin
          eng_rx = eng_shift;
          eng_sda = eng_ack_mode ? 1'b0 : 1'b1;
        end else if (eng_step == BYTE_STEPS + 1) eng_scl = 1'b1;
        else if (eng_step == BYTE_STEPS + 2) eng_scl = 1'b0;
        else eng_sda = 1'b0;
      end
    endcase
    eng_wait = (unit_ticks == 0) ? 0 : unit_ticks - 1;
  endfunction

  // Advance the engine copy by one tick and queue the status it must show.
  function automatic void engine_tick(input i2cm_item_t it);
    i2cm_res_t   st;
    logic        fin;
    int unsigned total;
    fin = 1'b0;
    if (!eng_busy) begin
      if (it.req >= REQ_INIT && it.req <= REQ_READ) begin
        eng_busy = 1'b1;
        eng_cmd = it.req;
        eng_step = 0;
        if (it.req == REQ_WRITE) eng_shift = it.tx;
        if (it.req == REQ_READ) begin
          eng_shift = '0;
          eng_ack_mode = it.send_ack;
        end
        apply_step(it.sda_in);
      end
    end else if (eng_wait > 0) begin
      eng_wait--;
    end else begin
      case (eng_cmd)
        REQ_INIT, REQ_STOP: total = 2;
        REQ_START:          total = 3;
        default:            total = BYTE_STEPS + 4;
      endcase
      eng_step++;
      if (eng_step >= total) begin
        eng_busy = 1'b0;
        eng_step = 0;
        fin = 1'b1;
      end else begin
        apply_step(it.sda_in);
      end
    end
    st.scl = eng_scl;
    st.sda = eng_sda;
    st.busy = eng_busy;
    st.done = fin;
    st.rx = eng_rx;
    st.ack = eng_ack;
    status_q.push_back(st);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : check_status
    i2cm_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: status transfer expected none actual scl %0b sda %0b", $time,
                 out_scl_level, out_sda_level);
        n_errors++;
      end else begin
        want = status_q.pop_front();
        check_field("scl_level", want.scl, out_scl_level);
        check_field("sda_level", want.sda, out_sda_level);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("done_res", want.done, out_done_res);
        check_field("rx_byte", want.rx, out_rx_byte);
        check_field("ack_received", want.ack, out_ack_received);
      end
    end
  end

  // Receiver: stall bursts, with ready stretches in between.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
    end
  end

  function automatic logic pick_sda(input int sda_pick);
    return (sda_pick == SDA_RAND) ? 1'($urandom) : sda_pick[0];
  endfunction

  task automatic send_tick(input i2cm_item_t it);
    if (!calm && !quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= it.req;
    in_tx_byte  <= it.tx;
    in_send_ack <= it.send_ack;
    in_sda_in   <= it.sda_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    engine_tick(it);
    if ($urandom_range(0, 199) == 0) quiet = !quiet;
  endtask

  // Tick until the running command ends; flood puts requests on busy ticks.
  task automatic run_out(input int sda_pick, input bit flood);
    i2cm_item_t it;
    while (eng_busy) begin
      it.req = flood ? 3'($urandom_range(0, 7)) : REQ_NONE;
      it.tx = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in = pick_sda(sda_pick);
      send_tick(it);
    end
  endtask

  task automatic send_cmd(input logic [2:0] req, input logic [7:0] tx, input logic ack,
                          input int sda_pick);
    i2cm_item_t it;
    it.req = req;
    it.tx = tx;
    it.send_ack = ack;
    it.sda_in = pick_sda(sda_pick);
    send_tick(it);
    run_out(sda_pick, 1'b0);
  endtask

  task automatic wait_drained();
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_unit_ticks(input logic [DELAY_WIDTH-1:0] v);
    run_out(SDA_RAND, 1'b0);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid       <= 1'b1;
    cfg_delay_ticks <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    unit_ticks = v;
  endtask

  task automatic test_reset_unit();
    send_cmd(REQ_INIT, 8'h00, 1'b0, SDA_RAND);
    send_cmd(REQ_START, 8'h00, 1'b0, SDA_RAND);
    send_cmd(REQ_WRITE, 8'hA5, 1'b0, SDA_LOW);
    send_cmd(REQ_READ, 8'h00, 1'b1, SDA_RAND);
    send_cmd(REQ_STOP, 8'h00, 1'b0, SDA_RAND);
  endtask

  // Zero unit acts as one tick; all-ones and all-zeros bytes both ways.
  task automatic test_byte_extremes();
    set_unit_ticks('0);
    send_cmd(REQ_START, 8'h00, 1'b0, SDA_RAND);
    send_cmd(REQ_WRITE, 8'hFF, 1'b0, SDA_LOW);
    send_cmd(REQ_WRITE, 8'h00, 1'b1, SDA_HIGH);
    send_cmd(REQ_READ, 8'hFF, 1'b1, SDA_HIGH);
    send_cmd(REQ_READ, 8'h00, 1'b0, SDA_LOW);
    send_cmd(REQ_STOP, 8'hFF, 1'b1, SDA_RAND);
    send_cmd(REQ_INIT, 8'hFF, 1'b1, SDA_RAND);
  endtask

  // Spare codes act as none; requests on busy and done ticks are dropped.
  task automatic test_odd_requests();
    i2cm_item_t it;
    set_unit_ticks(DELAY_WIDTH'(1));
    send_cmd(REQ_SPARE_6, 8'h3C, 1'b1, SDA_RAND);
    send_cmd(REQ_SPARE_7, 8'hC3, 1'b0, SDA_RAND);
    send_cmd(REQ_NONE, 8'h5A, 1'b1, SDA_RAND);
    it.req = REQ_WRITE;
    it.tx = 8'h96;
    it.send_ack = 1'b0;
    it.sda_in = 1'b0;
    send_tick(it);
    run_out(SDA_RAND, 1'b1);
    it.req = REQ_READ;
    it.send_ack = 1'b1;
    send_tick(it);
    run_out(SDA_RAND, 1'b1);
  endtask

  // Mostly start / byte / stop transactions, some broken ones and noise.
  task automatic test_random(input int n, input logic [DELAY_WIDTH-1:0] unit);
    i2cm_item_t  it;
    bit          in_xfer;
    int unsigned roll;
    int unsigned pick;
    in_xfer = 1'b0;
    set_unit_ticks(unit);
    repeat (n) begin
      it.tx = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (eng_busy) begin
        it.req = (roll < 15) ? 3'($urandom_range(0, 7)) : REQ_NONE;
      end else if (roll < 75) begin
        if (!in_xfer) begin
          it.req = ($urandom_range(0, 5) == 0) ? REQ_INIT : REQ_START;
          in_xfer = (it.req == REQ_START);
        end else begin
          pick = $urandom_range(0, 9);
          it.req = (pick < 4) ? REQ_WRITE : (pick < 8) ? REQ_READ : REQ_STOP;
          if (it.req == REQ_STOP) in_xfer = 1'b0;
        end
      end else if (roll < 88) begin
        it.req = 3'($urandom_range(0, 7));
      end else begin
        it.req = REQ_NONE;
      end
      send_tick(it);
    end
  endtask

  // Longest unit, with no idling on either side; the lines hold through
  // the first unit while stray requests are dropped.
  task automatic test_long_unit();
    i2cm_item_t it;
    calm = 1'b1;
    set_unit_ticks('1);
    it.req = REQ_INIT;
    it.tx = 8'h00;
    it.send_ack = 1'b0;
    it.sda_in = 1'($urandom);
    send_tick(it);
    repeat (LONG_TICKS) begin
      it.req = 3'($urandom_range(0, 7));
      it.tx = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in = 1'($urandom);
      send_tick(it);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_unit();
    test_byte_extremes();
    test_odd_requests();
    test_random(250, DELAY_WIDTH'(1));
    test_random(200, DELAY_WIDTH'(2));
    test_random(150, DELAY_WIDTH'(3));
    test_random(100, DELAY_WIDTH'($urandom_range(4, 9)));
    test_long_unit();
    in_valid <= 1'b0;
    wait_drained();
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_back.sv
rtl/i2c_master_bit_engine_top.sv
tb/tb_top.sv
